// File: design/rsc_pkg.sv
// shared types and constants for the rectangle split and clip block
package rsc_pkg;

  localparam int COORD_W = 16;
  localparam int NPIECE  = 4;
  localparam int SEL_W   = $clog2(NPIECE);

  // piece slots in emission order
  localparam int P_RIGHT = 0;
  localparam int P_LEFT  = 1;
  localparam int P_BELOW = 2;
  localparam int P_ABOVE = 3;

  typedef enum logic {
    MODE_SUB   = 1'b0,
    MODE_ISECT = 1'b1
  } mode_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } rect_t;

  typedef rect_t [NPIECE-1:0] piece_set_t;
  typedef logic [NPIECE-1:0]  pmask_t;

endpackage

// File: design/rect_split_clip.sv
// top level of the rectangle split and clip block
// Takes two inclusive signed rectangles A and B per item. Subtract mode emits the parts of A
// outside B (right, left, below, above), or A whole when they are disjoint; intersect mode
// emits the overlap, or nothing. An item yields zero to four results, one per cycle unless
// out_ready stalls them, the final one marked by out_last_piece. Items pass two compare/cut
// register stages, a piece serializer and an output register; the serializer takes a new
// item as it hands over the last piece of the previous one.
module rect_split_clip (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_a_min_x,
  input  logic [15:0] in_a_min_y,
  input  logic [15:0] in_a_max_x,
  input  logic [15:0] in_a_max_y,
  input  logic [15:0] in_b_min_x,
  input  logic [15:0] in_b_min_y,
  input  logic [15:0] in_b_max_x,
  input  logic [15:0] in_b_max_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_min_x,
  output logic [15:0] out_min_y,
  output logic [15:0] out_max_x,
  output logic [15:0] out_max_y,
  output logic        out_last_piece
);
  import rsc_pkg::*;

  rect_t      a, b, res;
  piece_set_t pieces;
  pmask_t     mask;
  logic       cut_valid, cut_ready;

  assign a = '{x0: coord_t'(in_a_min_x), y0: coord_t'(in_a_min_y),
               x1: coord_t'(in_a_max_x), y1: coord_t'(in_a_max_y)};
  assign b = '{x0: coord_t'(in_b_min_x), y0: coord_t'(in_b_min_y),
               x1: coord_t'(in_b_max_x), y1: coord_t'(in_b_max_y)};

  rsc_cut u_cut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_a       (a),
    .in_b       (b),
    .out_valid  (cut_valid),
    .out_ready  (cut_ready),
    .out_pieces (pieces),
    .out_mask   (mask)
  );

  rsc_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cut_valid),
    .in_ready  (cut_ready),
    .in_pieces (pieces),
    .in_mask   (mask),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rect  (res),
    .out_last  (out_last_piece)
  );

  assign out_min_x = res.x0;
  assign out_min_y = res.y0;
  assign out_max_x = res.x1;
  assign out_max_y = res.y1;

endmodule

// File: design/rsc_cut.sv
// compare and cut stages: two registered stages that turn a rectangle pair into pieces
module rsc_cut (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  rsc_pkg::rect_t      in_a,
  input  rsc_pkg::rect_t      in_b,
  output logic                out_valid,
  input  logic                out_ready,
  output rsc_pkg::piece_set_t out_pieces,
  output rsc_pkg::pmask_t     out_mask
);
  import rsc_pkg::*;

  // stage 1: edge compares
  logic   s1_valid_r, s1_valid_nxt;
  logic   s1_isect_r;
  logic   s1_hit_r;
  logic   s1_cr_r, s1_cl_r, s1_cb_r, s1_ct_r;
  rect_t  s1_a_r, s1_b_r;

  // stage 2: pieces
  logic       s2_valid_r, s2_valid_nxt;
  piece_set_t s2_pieces_r, s2_pieces_nxt;
  pmask_t     s2_mask_r, s2_mask_nxt;

  logic s1_take, s2_take, s2_free;
  logic hit, cr, cl, cb, ct;

  coord_t bx1p, bx0m, by1p, by0m;
  coord_t ax0c, ax1c, ay0c, ay1c;
  rect_t  whole_r;

  always_comb begin
    hit = !((in_b.x1 < in_a.x0) || (in_b.x0 > in_a.x1) ||
            (in_b.y1 < in_a.y0) || (in_b.y0 > in_a.y1));
    cr  = in_b.x1 < in_a.x1;
    cl  = in_b.x0 > in_a.x0;
    cb  = in_b.y1 < in_a.y1;
    ct  = in_b.y0 > in_a.y0;
  end

  assign s2_free  = !s2_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_free;
  assign s1_take  = in_valid && in_ready;
  assign s2_take  = s1_valid_r && s2_free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  // cut geometry from registered compares
  always_comb begin
    bx1p = s1_b_r.x1 + coord_t'(1);
    bx0m = s1_b_r.x0 - coord_t'(1);
    by1p = s1_b_r.y1 + coord_t'(1);
    by0m = s1_b_r.y0 - coord_t'(1);
    ax1c = s1_cr_r ? s1_b_r.x1 : s1_a_r.x1;
    ax0c = s1_cl_r ? s1_b_r.x0 : s1_a_r.x0;
    ay1c = s1_cb_r ? s1_b_r.y1 : s1_a_r.y1;
    ay0c = s1_ct_r ? s1_b_r.y0 : s1_a_r.y0;
    whole_r = s1_a_r;

    s2_pieces_nxt[P_RIGHT] = '{x0: bx1p,        y0: s1_a_r.y0, x1: s1_a_r.x1, y1: s1_a_r.y1};
    s2_pieces_nxt[P_LEFT]  = '{x0: s1_a_r.x0,   y0: s1_a_r.y0, x1: bx0m,      y1: s1_a_r.y1};
    s2_pieces_nxt[P_BELOW] = '{x0: ax0c,        y0: by1p,      x1: ax1c,      y1: s1_a_r.y1};
    s2_pieces_nxt[P_ABOVE] = '{x0: ax0c,        y0: s1_a_r.y0, x1: ax1c,      y1: by0m};
    s2_mask_nxt = '0;

    if (s1_isect_r) begin
      s2_pieces_nxt[P_RIGHT] = '{x0: ax0c, y0: ay0c, x1: ax1c, y1: ay1c};
      s2_mask_nxt[P_RIGHT]   = s1_hit_r;
    end else if (!s1_hit_r) begin
      s2_pieces_nxt[P_RIGHT] = whole_r;
      s2_mask_nxt[P_RIGHT]   = 1'b1;
    end else begin
      s2_mask_nxt[P_RIGHT] = s1_cr_r;
      s2_mask_nxt[P_LEFT]  = s1_cl_r;
      s2_mask_nxt[P_BELOW] = s1_cb_r;
      s2_mask_nxt[P_ABOVE] = s1_ct_r;
    end
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (s2_free) begin
      s2_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_isect_r <= (in_mode == MODE_ISECT);
      s1_hit_r   <= hit;
      s1_cr_r    <= cr;
      s1_cl_r    <= cl;
      s1_cb_r    <= cb;
      s1_ct_r    <= ct;
      s1_a_r     <= in_a;
      s1_b_r     <= in_b;
    end
    if (s2_take) begin
      s2_pieces_r <= s2_pieces_nxt;
      s2_mask_r   <= s2_mask_nxt;
    end
  end

  assign out_valid  = s2_valid_r;
  assign out_pieces = s2_pieces_r;
  assign out_mask   = s2_mask_r;

endmodule

// File: design/rsc_ser.sv
// piece serializer and output register: one piece per cycle unless out_ready stalls, last flag on the final one
module rsc_ser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsc_pkg::piece_set_t in_pieces,
  input  rsc_pkg::pmask_t     in_mask,
  output logic                out_valid,
  input  logic                out_ready,
  output rsc_pkg::rect_t      out_rect,
  output logic                out_last
);
  import rsc_pkg::*;

  piece_set_t pieces_r;
  pmask_t     mask_r, mask_nxt;
  logic       out_valid_r, out_valid_nxt;
  rect_t      out_rect_r;
  logic       out_last_r;

  logic       [SEL_W-1:0] sel;
  pmask_t     rest;
  logic       out_ld, take;

  // lowest pending slot goes first
  always_comb begin
    sel = '0;
    for (int i = NPIECE - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = SEL_W'(i);
      end
    end
  end

  assign rest     = mask_r & (mask_r - pmask_t'(1));
  assign out_ld   = (|mask_r) && (!out_valid_r || out_ready);
  assign take     = (mask_r == '0) || (out_ld && (rest == '0));
  assign in_ready = take;

  always_comb begin
    mask_nxt = mask_r;
    if (in_valid && take) begin
      mask_nxt = in_mask;
    end else if (out_ld) begin
      mask_nxt = rest;
    end
    out_valid_nxt = out_valid_r;
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && take) begin
      pieces_r <= in_pieces;
    end
    if (out_ld) begin
      out_rect_r <= pieces_r[sel];
      out_last_r <= (rest == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_rect  = out_rect_r;
  assign out_last  = out_last_r;

endmodule

// File: tb/tb_rect_split_clip.sv
// testbench for rect_split_clip: directed table plus random items, checked against table entries or a predictor
module tb_rect_split_clip;
  import rsc_pkg::*;

  localparam int N_DIR      = 17;
  localparam int N_ITEMS    = 330;
  localparam int N_QUIET    = 50;
  localparam int HOLD_LEN   = 80;
  localparam int HOLD_AT    = 150;
  localparam int DRAIN_WAIT = 16;
  localparam int LIMIT      = 200000;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    logic   last;
  } piece_t;

  typedef struct packed {
    mode_t m;
    rect_t a;
    rect_t b;
    logic  typed;
    logic  want_one;
    rect_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [15:0] in_a_min_x, in_a_min_y, in_a_max_x, in_a_max_y;
  logic [15:0] in_b_min_x, in_b_min_y, in_b_max_x, in_b_max_y;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_min_x, out_min_y, out_max_x, out_max_y;
  logic        out_last_piece;

  piece_t    piece_q[$];
  stim_row_t dir_tab [N_DIR];
  int        errors = 0;
  int        cycles = 0;
  int        n_sub = 0, n_isect = 0, n_checked = 0, n_four = 0, n_none = 0;
  bit        quiet = 1'b0;

  rect_split_clip dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_a_min_x(in_a_min_x), .in_a_min_y(in_a_min_y),
    .in_a_max_x(in_a_max_x), .in_a_max_y(in_a_max_y),
    .in_b_min_x(in_b_min_x), .in_b_min_y(in_b_min_y),
    .in_b_max_x(in_b_max_x), .in_b_max_y(in_b_max_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_min_x(out_min_x), .out_min_y(out_min_y),
    .out_max_x(out_max_x), .out_max_y(out_max_y),
    .out_last_piece(out_last_piece)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d rectangles still expected", cycles, piece_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic rect_t rc(int x0, int y0, int x1, int y1);
    rect_t r;
    r.x0 = coord_t'(x0);
    r.y0 = coord_t'(y0);
    r.x1 = coord_t'(x1);
    r.y1 = coord_t'(y1);
    return r;
  endfunction

  function automatic coord_t clip16(int v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  // pieces of A outside B, or the overlap, queued in emission order
  function automatic int predict_pieces(mode_t m, rect_t a, rect_t b);
    rect_t  r [NPIECE];
    rect_t  p;
    int     n;
    logic   hit;
    piece_t pc;
    n = 0;
    hit = !(b.x1 < a.x0 || b.x0 > a.x1 || b.y1 < a.y0 || b.y0 > a.y1);
    if (m == MODE_SUB) begin
      if (!hit) begin
        r[n] = a;
        n++;
      end else begin
        if (b.x1 < a.x1) begin
          p = a;
          p.x0 = b.x1 + coord_t'(1);
          r[n] = p;
          n++;
          a.x1 = b.x1;
        end
        if (b.x0 > a.x0) begin
          p = a;
          p.x1 = b.x0 - coord_t'(1);
          r[n] = p;
          n++;
          a.x0 = b.x0;
        end
        if (b.y1 < a.y1) begin
          p = a;
          p.y0 = b.y1 + coord_t'(1);
          r[n] = p;
          n++;
          a.y1 = b.y1;
        end
        if (b.y0 > a.y0) begin
          p = a;
          p.y1 = b.y0 - coord_t'(1);
          r[n] = p;
          n++;
          a.y0 = b.y0;
        end
      end
    end else if (hit) begin
      if (b.x1 < a.x1) a.x1 = b.x1;
      if (b.x0 > a.x0) a.x0 = b.x0;
      if (b.y1 < a.y1) a.y1 = b.y1;
      if (b.y0 > a.y0) a.y0 = b.y0;
      r[n] = a;
      n++;
    end
    for (int k = 0; k < n; k++) begin
      pc.x0 = r[k].x0;
      pc.y0 = r[k].y0;
      pc.x1 = r[k].x1;
      pc.y1 = r[k].y1;
      pc.last = (k == n - 1);
      piece_q.push_back(pc);
    end
    return n;
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 6))
      0: return coord_t'(-32768);
      1: return coord_t'(-32767);
      2: return coord_t'(-1);
      3: return coord_t'(0);
      4: return coord_t'(1);
      5: return coord_t'(32766);
      default: return coord_t'(32767);
    endcase
  endfunction

  task automatic rand_pair(output mode_t m, output rect_t a, output rect_t b);
    int sel, ax, ay, wx, wy;
    sel = $urandom_range(0, 99);
    m = ($urandom_range(0, 9) < 3) ? MODE_ISECT : MODE_SUB;
    ax = int'($urandom_range(0, 65535)) - 32768;
    ay = int'($urandom_range(0, 65535)) - 32768;
    wx = $urandom_range(0, 40);
    wy = $urandom_range(0, 40);
    a.x0 = clip16(ax);
    a.y0 = clip16(ay);
    a.x1 = clip16(ax + wx);
    a.y1 = clip16(ay + wy);
    if (sel < 60) begin
      // b placed around a so that most pairs overlap
      b.x0 = clip16(ax + int'($urandom_range(0, 2 * wx + 10)) - wx - 5);
      b.y0 = clip16(ay + int'($urandom_range(0, 2 * wy + 10)) - wy - 5);
      b.x1 = clip16(int'(b.x0) + int'($urandom_range(0, 40)));
      b.y1 = clip16(int'(b.y0) + int'($urandom_range(0, 40)));
    end else if (sel < 75) begin
      a = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
      b = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
    end else if (sel < 90) begin
      a = {$urandom(), $urandom()};
      b = {$urandom(), $urandom()};
    end else begin
      b.x0 = clip16(ax - int'($urandom_range(0, 3)));
      b.y0 = clip16(ay - int'($urandom_range(0, 3)));
      b.x1 = clip16(ax + wx + int'($urandom_range(0, 3)));
      b.y1 = clip16(ay + wy + int'($urandom_range(0, 3)));
    end
  endtask

  task automatic offer(mode_t m, rect_t a, rect_t b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= m;
    in_a_min_x <= a.x0;
    in_a_min_y <= a.y0;
    in_a_max_x <= a.x1;
    in_a_max_y <= a.y1;
    in_b_min_x <= b.x0;
    in_b_min_y <= b.y0;
    in_b_max_x <= b.x1;
    in_b_max_y <= b.y1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (m == MODE_SUB) n_sub++;
    else n_isect++;
  endtask

  task automatic note_fail(string what);
    errors++;
    if (errors <= 10) $display("%0d: %s", cycles, what);
  endtask

  function automatic void tally(int n);
    if (n == 0) n_none++;
    if (n == NPIECE) n_four++;
  endfunction

  // receiver: checks each rectangle, stalls in bursts, holds off once for a long stretch
  initial begin
    piece_t got, want;
    int     stall_left, hold_left;
    bit     held;
    stall_left = 0;
    hold_left = 0;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) begin
        got = {out_min_x, out_min_y, out_max_x, out_max_y, out_last_piece};
        n_checked++;
        if (piece_q.size() == 0) begin
          note_fail($sformatf("unexpected rectangle (%0d,%0d)-(%0d,%0d) last %0b",
                              got.x0, got.y0, got.x1, got.y1, got.last));
        end else begin
          want = piece_q.pop_front();
          if (got !== want)
            note_fail($sformatf("expected (%0d,%0d)-(%0d,%0d) last %0b, got (%0d,%0d)-(%0d,%0d) last %0b",
                                want.x0, want.y0, want.x1, want.y1, want.last,
                                got.x0, got.y0, got.x1, got.y1, got.last));
        end
      end
      if (!held && n_checked >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0 && !quiet) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // sender: reset, directed table, random items, drain and verdict
  initial begin
    mode_t m;
    rect_t a, b;
    int    n;
    piece_t pc;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_mode    <= MODE_SUB;
    in_a_min_x <= '0;
    in_a_min_y <= '0;
    in_a_max_x <= '0;
    in_a_max_y <= '0;
    in_b_min_x <= '0;
    in_b_min_y <= '0;
    in_b_max_x <= '0;
    in_b_max_y <= '0;

    dir_tab[0]  = '{MODE_SUB, rc(0, 0, 10, 10), rc(20, 20, 30, 30), 1'b1, 1'b1, rc(0, 0, 10, 10)};
    dir_tab[1]  = '{MODE_ISECT, rc(0, 0, 10, 10), rc(20, 20, 30, 30), 1'b1, 1'b0, rc(0, 0, 0, 0)};
    dir_tab[2]  = '{MODE_SUB, rc(5, 5, 6, 6), rc(0, 0, 10, 10), 1'b1, 1'b0, rc(0, 0, 0, 0)};
    dir_tab[3]  = '{MODE_ISECT, rc(-7, -7, 7, 7), rc(-7, -7, 7, 7), 1'b1, 1'b1, rc(-7, -7, 7, 7)};
    dir_tab[4]  = '{MODE_SUB, rc(0, 0, 20, 20), rc(5, 5, 15, 15), 1'b0, 1'b0, rc(0, 0, 0, 0)};
    dir_tab[5]  = '{MODE_SUB, rc(-32768, -32768, 32767, 32767), rc(0, 0, 0, 0),
                    1'b0, 1'b0, rc(0, 0, 0, 0)};
    dir_tab[6]  = '{MODE_ISECT, rc(-32768, -32768, 32767, 32767), rc(-3, 4, 100, 200),
                    1'b1, 1'b1, rc(-3, 4, 100, 200)};
    dir_tab[7]  = '{MODE_SUB, rc(-32768, -32768, 32767, 32767), rc(-32768, -32768, 32767, 32767),
                    1'b1, 1'b0, rc(0, 0, 0, 0)};
    dir_tab[8]  = '{MODE_SUB, rc(0, 0, 10, 10), rc(5, -5, 20, 20), 1'b0, 1'b0, rc(0, 0, 0, 0)};
    dir_tab[9]  = '{MODE_SUB, rc(10, 10, 0, 0), rc(0, 0, 10, 10), 1'b0, 1'b0, rc(0, 0, 0, 0)};
    dir_tab[10] = '{MODE_SUB, rc(0, 0, 10, 10), rc(10, 10, 20, 20), 1'b0, 1'b0, rc(0, 0, 0, 0)};
    dir_tab[11] = '{MODE_ISECT, rc(-32768, -32768, 32767, 32767), rc(-32768, -32768, 32767, 32767),
                    1'b1, 1'b1, rc(-32768, -32768, 32767, 32767)};
    dir_tab[12] = '{MODE_SUB, rc(-32768, -32768, 32767, 32767), rc(32767, 32767, 32767, 32767),
                    1'b0, 1'b0, rc(0, 0, 0, 0)};
    dir_tab[13] = '{MODE_SUB, rc(-32768, -32768, 32767, 32767), rc(-32768, -32768, -32768, -32768),
                    1'b0, 1'b0, rc(0, 0, 0, 0)};
    dir_tab[14] = '{MODE_ISECT, rc(10, 10, -10, -10), rc(-5, -5, 5, 5), 1'b0, 1'b0, rc(0, 0, 0, 0)};
    dir_tab[15] = '{MODE_SUB, rc(0, 0, 0, 0), rc(1, 1, 5, 5), 1'b1, 1'b1, rc(0, 0, 0, 0)};
    dir_tab[16] = '{MODE_ISECT, rc(-32768, 0, -32768, 0), rc(-32768, 0, -32768, 0),
                    1'b1, 1'b1, rc(-32768, 0, -32768, 0)};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      offer(dir_tab[i].m, dir_tab[i].a, dir_tab[i].b);
      if (dir_tab[i].typed) begin
        n = dir_tab[i].want_one;
        if (dir_tab[i].want_one) begin
          pc = {dir_tab[i].want, 1'b1};
          piece_q.push_back(pc);
        end
      end else begin
        n = predict_pieces(dir_tab[i].m, dir_tab[i].a, dir_tab[i].b);
      end
      tally(n);
    end

    for (int i = N_DIR; i < N_ITEMS; i++) begin
      if (i >= N_ITEMS - N_QUIET) quiet = 1'b1;
      rand_pair(m, a, b);
      offer(m, a, b);
      tally(predict_pieces(m, a, b));
    end
    in_valid <= 1'b0;

    while (piece_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (piece_q.size() != 0) note_fail($sformatf("%0d rectangles never arrived", piece_q.size()));

    $display("covered %0d items (%0d subtract, %0d intersect), %0d rectangles checked",
             n_sub + n_isect, n_sub, n_isect, n_checked);
    $display("items giving four pieces: %0d, giving none: %0d, mismatches: %0d",
             n_four, n_none, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/rsc_pkg.sv
design/rsc_cut.sv
design/rsc_ser.sv
design/rect_split_clip.sv
tb/tb_rect_split_clip.sv
